[hw/rtl/bdq_pkg.sv]
// bdq_pkg: shared constants, operation and status codes, and the
// command/status structs between the deque controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DataW        = 32;
  localparam int CntW         = 7;
  localparam int FuncW        = 2;
  localparam int StatusW      = 2;
  localparam int DefaultDepth = 64;

  localparam logic [CntW-1:0] CapReset = 7'd64;

  localparam logic [FuncW-1:0] FuncPushFront = 2'd0;
  localparam logic [FuncW-1:0] FuncPushBack  = 2'd1;
  localparam logic [FuncW-1:0] FuncPopFront  = 2'd2;
  localparam logic [FuncW-1:0] FuncPopBack   = 2'd3;

  localparam logic [StatusW-1:0] StatusDone  = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic take_item;  // latch the incoming transaction
    logic execute;    // perform the storage access and pointer update
    logic publish;    // load the result registers
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_pending;  // a result is held and not yet taken
  } stat_t;

endpackage

[hw/rtl/bdq_ctrl.sv]
// bdq_ctrl: sequencing state machine for the bounded deque.
// Depends on bdq_pkg (cmd_t, stat_t).
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  input  bdq_pkg::stat_t stat_i,
  output bdq_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       can_publish;

  assign in_ready_o  = (state_q == StIdle);
  assign can_publish = !stat_i.out_pending || out_ready_i;

  always_comb begin
    cmd_o.take_item = in_valid_i && in_ready_o;
    cmd_o.execute   = (state_q == StExec);
    cmd_o.publish   = (state_q == StFin) && can_publish;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        state_d = StFin;
      end
      StFin: begin
        if (can_publish) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The access cycle always hands over to result capture
  a_exec_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> (state_q == StFin))
    else $error("bdq_ctrl: access cycle not followed by result capture");
`endif

endmodule

[hw/rtl/bdq_dpath.sv]
// bdq_dpath: entry storage, front pointer, count, capacity register and
// result registers of the bounded deque. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_dpath #(
  parameter int DEPTH = bdq_pkg::DefaultDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdq_pkg::cmd_t                     cmd_i,
  output bdq_pkg::stat_t                    stat_o,
  input  logic                              cfg_valid_i,
  input  logic [bdq_pkg::CntW-1:0]          cfg_data_i,
  input  logic [bdq_pkg::FuncW-1:0]         func_i,
  input  logic signed [bdq_pkg::DataW-1:0]  push_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [bdq_pkg::DataW-1:0]  pop_value_o,
  output logic [bdq_pkg::StatusW-1:0]       status_o,
  output logic [bdq_pkg::CntW-1:0]          fill_count_o
);

  localparam int IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW   = bdq_pkg::CntW;
  localparam int DataW  = bdq_pkg::DataW;
  localparam int SumW   = ((IdxW > CntW) ? IdxW : CntW) + 1;
  localparam int LimMax = (DEPTH < 127) ? DEPTH : 127;

  localparam logic [CntW-1:0] DepthLim = CntW'(LimMax);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  logic [DataW-1:0]            mem_q [DEPTH];
  logic [bdq_pkg::FuncW-1:0]   func_q;
  logic [DataW-1:0]            value_q;
  logic [IdxW-1:0]             front_q;
  logic [CntW-1:0]             count_q;
  logic [CntW-1:0]             cap_q;
  logic [DataW-1:0]            rd_q;
  logic                        pop_ok_q;
  logic [bdq_pkg::StatusW-1:0] status_q;
  logic                        out_valid_q;
  logic [DataW-1:0]            pop_value_q;
  logic [bdq_pkg::StatusW-1:0] status_out_q;
  logic [CntW-1:0]             fill_q;

  logic [CntW-1:0] limit;
  logic            is_push, push_ok, pop_ok;
  logic [IdxW-1:0] front_dec, front_inc, back_slot, back_last;
  logic [SumW-1:0] sum_slot, sum_last;
  logic            we, re;
  logic [IdxW-1:0] wa, ra;

  assign limit = (cap_q > DepthLim) ? DepthLim : cap_q;

  assign is_push = (func_q == bdq_pkg::FuncPushFront) || (func_q == bdq_pkg::FuncPushBack);
  assign push_ok = (count_q < limit);
  assign pop_ok  = (count_q != '0);

  // Circular index arithmetic; every sum stays below twice the depth
  assign front_dec = (front_q == '0) ? LastIdx : front_q - IdxW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + IdxW'(1);
  assign sum_slot  = SumW'(front_q) + SumW'(count_q);
  assign sum_last  = sum_slot - SumW'(1);
  assign back_slot = (sum_slot >= DepthSum) ? IdxW'(sum_slot - DepthSum) : IdxW'(sum_slot);
  assign back_last = (sum_last >= DepthSum) ? IdxW'(sum_last - DepthSum) : IdxW'(sum_last);

  assign we = cmd_i.execute && is_push && push_ok;
  assign re = cmd_i.execute && !is_push && pop_ok;
  assign wa = (func_q == bdq_pkg::FuncPushFront) ? front_dec : back_slot;
  assign ra = (func_q == bdq_pkg::FuncPopFront) ? front_q : back_last;

  // Storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= value_q;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  // Latched transaction, per-item flags and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      func_q  <= func_i;
      value_q <= push_value_i;
    end
    if (cmd_i.execute) begin
      pop_ok_q <= !is_push && pop_ok;
      if (is_push) begin
        status_q <= push_ok ? bdq_pkg::StatusDone : bdq_pkg::StatusFull;
      end else begin
        status_q <= pop_ok ? bdq_pkg::StatusDone : bdq_pkg::StatusEmpty;
      end
    end
    if (cmd_i.publish) begin
      pop_value_q  <= pop_ok_q ? rd_q : '0;
      status_out_q <= status_q;
      fill_q       <= count_q;
    end
  end

  // Pointer, count, capacity and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      cap_q       <= bdq_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (we) begin
        count_q <= count_q + CntW'(1);
        if (func_q == bdq_pkg::FuncPushFront) front_q <= front_dec;
      end else if (re) begin
        count_q <= count_q - CntW'(1);
        if (func_q == bdq_pkg::FuncPopFront) front_q <= front_inc;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_pending = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign pop_value_o        = pop_value_q;
  assign status_o           = status_out_q;
  assign fill_count_o       = fill_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthLim)
    else $error("bdq_dpath: entry count beyond built depth");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("bdq_dpath: read and write in the same access cycle");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(count_q) && $stable(front_q))
    else $error("bdq_dpath: pointer state moved outside an access cycle");
`endif

endmodule

[hw/rtl/bounded_deque_core.sv]
// bounded_deque_core: top level of the bounded double-ended queue.
// Depends on bdq_pkg, bdq_ctrl and bdq_dpath.
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit words held in a circular buffer of DEPTH
// entries with a front pointer and an entry count. Each input transaction
// carries one operation (push front, push back, pop front, pop back) and
// yields exactly one result transaction with the popped word (zero unless a
// pop succeeded), a status code (done, full, empty) and the fill count after
// the operation. A push is refused while the count has reached the smaller of
// the capacity register and DEPTH; a refused operation leaves the state
// untouched. Timing: after the accepting edge an item goes through storage
// access, then result capture, which follows because the entry storage has a
// registered read port. One item is in flight at a time: a new transaction is
// accepted only once the previous one has been through result capture. A new
// transaction is accepted while the previous result still waits on the output
// register; result capture then stalls until that register is taken. The
// storage is not cleared after reset: no sequence of operations can read an
// entry that was not pushed. The capacity register (reset 64) is written
// through the cfg channel, which is always ready; write it only while no
// transaction is in flight.
module bounded_deque_core #(
  parameter int DEPTH = bdq_pkg::DefaultDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: capacity register
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdq_pkg::CntW-1:0]          cfg_data_i,
  // Operation channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bdq_pkg::FuncW-1:0]         func_i,
  input  logic signed [bdq_pkg::DataW-1:0]  push_value_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bdq_pkg::DataW-1:0]  pop_value_o,
  output logic [bdq_pkg::StatusW-1:0]       status_o,
  output logic [bdq_pkg::CntW-1:0]          fill_count_o
);

  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  // Capacity writes are always accepted
  assign cfg_ready_o = 1'b1;

  // Sequencer: accept, access, publish
  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage, pointers and result registers
  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .push_value_i (push_value_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o)
  );

endmodule
